[src/frr_pkg.sv]
// ----------------------------------------------------------------------------
// frr_pkg: shared types and constants for the framed record receiver
// Control codes, phase encoding and the front-to-back command word.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;

    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_CAN = 8'h18;
    localparam logic [7:0] C_ESC = 8'h1b;
    localparam logic [7:0] C_CR  = 8'h0d;
    localparam logic [7:0] C_LF  = 8'h0a;

    localparam logic [7:0] RETRY_RESET = 8'd10;

    localparam logic REG_BINARY_MODE = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    localparam logic [1:0] FS_NONE     = 2'd0;
    localparam logic [1:0] FS_COMPLETE = 2'd1;
    localparam logic [1:0] FS_CANCEL   = 2'd2;
    localparam logic [1:0] FS_END      = 2'd3;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_NAKWAIT = 9'b000000010,
        PH_CNTHI   = 9'b000000100,
        PH_CNTLO   = 9'b000001000,
        PH_PAYLOAD = 9'b000010000,
        PH_ETX     = 9'b000100000,
        PH_CHK     = 9'b001000000,
        PH_SEEK    = 9'b010000000,
        PH_EATCHK  = 9'b100000000
    } t_phase;

    typedef enum logic [2:0] {
        CMD_STATUS = 3'b001,
        CMD_REPLY  = 3'b010,
        CMD_DRAIN  = 3'b100
    } t_cmd_kind;

    // one command from front to back; drain releases count bytes, ACK with the last
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  code;
        logic [1:0]  status;
        logic [15:0] count;
    } t_cmd;

endpackage

[src/framed_record_receiver.sv]
// ----------------------------------------------------------------------------
// framed_record_receiver: receive side of a framed serial record protocol
// Parser front end, two-entry command queue, result sequencer back end.
//
//   channel   dir  tdata                       tuser        tlast
//   s_axis    in   rx_byte[7:0]                func         -
//   m_axis    out  data_byte, reply_byte       has_data,    last
//                                              has_reply,
//                                              file_status
//   cfg       in   index 0 binary_mode, 1 retry_limit
//
// Each received word is parsed as it is accepted; a good record then drains the
// store at one result word per cycle unless output stalls, via the read register.
// Reset is synchronous, active low; the store has no reset.
// Input stalls when the command queue is full, and in the payload phase while
// a command is queued or the store is still being drained; output stalls hold.
// ----------------------------------------------------------------------------
module framed_record_receiver #(
    parameter int BUFFER_DEPTH = frr_pkg::DEF_BUFFER_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] reply_byte
    output logic [3:0]  m_axis_tuser,   // [0] has_data, [1] has_reply, [3:2] file_status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic        r_binary_mode;
    logic [7:0]  r_retry_limit;
    logic        w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    frr_pkg::t_cmd w_fq_cmd, w_qb_cmd;
    logic        w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]  w_wr_data;
    logic        w_back_busy;
    logic        w_store_busy;

    assign o_cfg_ready  = 1'b1;
    assign w_store_busy = w_qb_valid || w_back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b0;
            r_retry_limit <= frr_pkg::RETRY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == frr_pkg::REG_BINARY_MODE) r_binary_mode <= i_cfg_data[0];
            if (i_cfg_index == frr_pkg::REG_RETRY_LIMIT) r_retry_limit <= i_cfg_data;
        end
    end

    frr_front #(.BUFFER_DEPTH(BUFFER_DEPTH), .AW(AW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_byte(s_axis_tdata),
        .i_binary_mode(r_binary_mode), .i_retry_limit(r_retry_limit),
        .i_store_busy(w_store_busy),
        .o_cmd_valid(w_fq_valid), .o_cmd(w_fq_cmd), .i_cmd_ready(w_fq_ready),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr), .o_wr_data(w_wr_data)
    );

    frr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fq_valid), .i_cmd(w_fq_cmd), .o_ready(w_fq_ready),
        .o_valid(w_qb_valid), .o_cmd(w_qb_cmd), .i_ready(w_qb_ready)
    );

    frr_back #(.BUFFER_DEPTH(BUFFER_DEPTH), .AW(AW)) u_back (
        .i_clk, .i_rst_n,
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_data(w_wr_data),
        .i_cmd_valid(w_qb_valid), .i_cmd(w_qb_cmd), .o_cmd_ready(w_qb_ready),
        .o_busy(w_back_busy),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data_byte(m_axis_tdata[7:0]), .o_reply_byte(m_axis_tdata[15:8]),
        .o_has_data(m_axis_tuser[0]), .o_has_reply(m_axis_tuser[1]),
        .o_status(m_axis_tuser[3:2]), .o_last(m_axis_tlast)
    );

endmodule

[src/frr_front.sv]
// ----------------------------------------------------------------------------
// frr_front: record parser
// Runs the record state machine on each word, stores the payload and
// issues one command per word that causes results.
// ----------------------------------------------------------------------------
module frr_front #(
    parameter int BUFFER_DEPTH = frr_pkg::DEF_BUFFER_DEPTH,
    parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [7:0]        i_byte,
    input  logic              i_binary_mode,
    input  logic [7:0]        i_retry_limit,
    input  logic              i_store_busy,
    output logic              o_cmd_valid,
    output frr_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_ready,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [7:0]        o_wr_data
);

    localparam logic [16:0] DEPTH17 = 17'(BUFFER_DEPTH);

    frr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_taken, n_taken;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_attempts, n_attempts;
    logic        r_overlong, n_overlong;

    logic        w_tick;
    logic        w_fire;
    logic        w_emit;
    logic        w_fail;
    logic [7:0]  w_lim;
    logic [7:0]  w_att_inc;
    logic [15:0] w_taken_inc;
    logic [15:0] w_cnt_full;
    frr_pkg::t_cmd w_cmd;

    assign w_tick      = i_func;
    // payload words wait while a command is queued or a good record is still read out of the store
    assign o_ready     = i_cmd_ready && !(r_phase == frr_pkg::PH_PAYLOAD && i_store_busy);
    assign w_fire      = i_valid && o_ready;
    assign w_lim       = (i_retry_limit == 8'd0) ? 8'd1 : i_retry_limit;
    assign w_att_inc   = r_attempts + 8'd1;
    assign w_taken_inc = r_taken + 16'd1;
    assign w_cnt_full  = {r_count[15:8], i_byte};

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_taken    = r_taken;
        n_check    = r_check;
        n_attempts = r_attempts;
        n_overlong = r_overlong;
        w_emit     = 1'b0;
        w_fail     = 1'b0;
        w_cmd      = '{kind: frr_pkg::CMD_REPLY, code: frr_pkg::C_NAK,
                       status: frr_pkg::FS_NONE, count: r_count};
        o_wr_en    = 1'b0;
        o_wr_addr  = r_taken[AW-1:0];
        o_wr_data  = (i_byte == frr_pkg::C_CR && !i_binary_mode) ? frr_pkg::C_LF : i_byte;
        case (r_phase)
            frr_pkg::PH_IDLE: begin
                if (!w_tick) begin
                    if (i_byte == frr_pkg::C_EOT || i_byte == frr_pkg::C_CAN ||
                        i_byte == frr_pkg::C_ESC) begin
                        w_emit      = 1'b1;
                        w_cmd.kind  = frr_pkg::CMD_STATUS;
                        w_cmd.status = (i_byte == frr_pkg::C_EOT) ? frr_pkg::FS_COMPLETE :
                                       (i_byte == frr_pkg::C_CAN) ? frr_pkg::FS_CANCEL :
                                       frr_pkg::FS_END;
                        n_attempts  = 8'd0;
                    end else if (i_byte == frr_pkg::C_STX) begin
                        n_phase = frr_pkg::PH_CNTHI;
                    end else if (i_byte == frr_pkg::C_ETX) begin
                        n_phase = frr_pkg::PH_EATCHK;
                    end else begin
                        n_phase = frr_pkg::PH_SEEK;
                    end
                end
            end
            frr_pkg::PH_NAKWAIT: begin
                if (w_tick) begin
                    w_emit = 1'b1;
                end else if (i_byte == frr_pkg::C_STX) begin
                    n_phase = frr_pkg::PH_CNTHI;
                end else if (i_byte == frr_pkg::C_ETX) begin
                    n_phase = frr_pkg::PH_EATCHK;
                end else begin
                    n_phase = frr_pkg::PH_SEEK;
                end
            end
            frr_pkg::PH_CNTHI: begin
                if (!w_tick) begin
                    n_count = {i_byte, 8'd0};
                    n_phase = frr_pkg::PH_CNTLO;
                end
            end
            frr_pkg::PH_CNTLO: begin
                if (!w_tick) begin
                    n_count    = w_cnt_full;
                    n_taken    = 16'd0;
                    n_check    = 8'd0;
                    n_overlong = ({1'b0, w_cnt_full} > DEPTH17);
                    n_phase    = (w_cnt_full == 16'd0) ? frr_pkg::PH_ETX : frr_pkg::PH_PAYLOAD;
                end
            end
            frr_pkg::PH_PAYLOAD: begin
                if (w_tick) begin
                    w_fail = 1'b1;
                end else begin
                    n_check = r_check ^ i_byte;
                    o_wr_en = w_fire && ({1'b0, r_taken} < DEPTH17);
                    n_taken = w_taken_inc;
                    if (w_taken_inc >= r_count) begin
                        n_phase = frr_pkg::PH_ETX;
                    end
                end
            end
            frr_pkg::PH_ETX: begin
                if (w_tick) begin
                    w_fail = 1'b1;
                end else begin
                    n_phase = (i_byte == frr_pkg::C_ETX) ? frr_pkg::PH_CHK : frr_pkg::PH_SEEK;
                end
            end
            frr_pkg::PH_CHK: begin
                if (!w_tick && i_byte == r_check && !r_overlong) begin
                    w_emit     = 1'b1;
                    w_cmd.kind = frr_pkg::CMD_DRAIN;
                    n_attempts = 8'd0;
                    n_phase    = frr_pkg::PH_IDLE;
                end else begin
                    w_fail = 1'b1;
                end
            end
            frr_pkg::PH_SEEK: begin
                if (w_tick) begin
                    w_fail = 1'b1;
                end else if (i_byte == frr_pkg::C_ETX) begin
                    n_phase = frr_pkg::PH_EATCHK;
                end
            end
            frr_pkg::PH_EATCHK: begin
                w_fail = 1'b1;
            end
            default: begin
                n_phase = frr_pkg::PH_IDLE;
            end
        endcase
        if (w_fail) begin
            w_emit = 1'b1;
            if (w_att_inc >= w_lim) begin
                w_cmd.code = frr_pkg::C_CAN;
                n_attempts = 8'd0;
                n_phase    = frr_pkg::PH_IDLE;
            end else begin
                n_attempts = w_att_inc;
                n_phase    = frr_pkg::PH_NAKWAIT;
            end
        end
    end

    assign o_cmd_valid = w_fire && w_emit;
    assign o_cmd       = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= frr_pkg::PH_IDLE;
            r_count    <= 16'd0;
            r_taken    <= 16'd0;
            r_check    <= 8'd0;
            r_attempts <= 8'd0;
            r_overlong <= 1'b0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_taken    <= n_taken;
            r_check    <= n_check;
            r_attempts <= n_attempts;
            r_overlong <= n_overlong;
        end
    end

    a_onehot_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase)) else $error("phase not one-hot");
    a_drain_clears_attempts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && o_cmd.kind == frr_pkg::CMD_DRAIN |=> r_attempts == 8'd0)
        else $error("attempts kept after good record");
    a_write_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> r_phase == frr_pkg::PH_PAYLOAD && !w_tick)
        else $error("store write outside payload");

endmodule

[src/frr_queue.sv]
// ----------------------------------------------------------------------------
// frr_queue: two-entry command queue
// Decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module frr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  frr_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output frr_pkg::t_cmd o_cmd,
    input  logic          i_ready
);

    frr_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

[src/frr_back.sv]
// ----------------------------------------------------------------------------
// frr_back: result sequencer
// Turns commands into result words, draining the record store for a
// good record; owns the payload memory.
// ----------------------------------------------------------------------------
module frr_back #(
    parameter int BUFFER_DEPTH = frr_pkg::DEF_BUFFER_DEPTH,
    parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_cmd_valid,
    input  frr_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    output logic          o_busy,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data_byte,
    output logic [7:0]    o_reply_byte,
    output logic          o_has_data,
    output logic          o_has_reply,
    output logic [1:0]    o_status,
    output logic          o_last
);

    localparam logic [15:0] DEPTH16 = 16'(BUFFER_DEPTH);

    logic [7:0]  r_store [BUFFER_DEPTH];
    logic [7:0]  r_rd;

    // read stage -> output register
    logic        r_busy;
    logic [15:0] r_idx;
    logic [15:0] r_len;
    logic        r_pend;
    logic        r_pend_last;
    logic        r_ov;
    logic        w_out_free;
    logic        w_issue;
    logic [15:0] w_len;

    assign w_out_free  = !r_ov || i_ready;
    assign o_cmd_ready = !r_busy && !r_pend && w_out_free;
    assign o_busy      = r_busy;
    assign w_len       = (i_cmd.count > DEPTH16) ? DEPTH16 : i_cmd.count;
    assign w_issue     = r_busy && (!r_pend || w_out_free);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
        if (w_issue) begin
            r_rd <= r_store[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (r_pend && w_out_free) begin
                r_pend       <= 1'b0;
                r_ov         <= 1'b1;
                o_has_data   <= 1'b1;
                o_data_byte  <= r_rd;
                o_has_reply  <= r_pend_last;
                o_reply_byte <= r_pend_last ? frr_pkg::C_ACK : 8'd0;
                o_status     <= frr_pkg::FS_NONE;
                o_last       <= r_pend_last;
            end
            if (w_issue) begin
                r_pend      <= 1'b1;
                r_pend_last <= (r_idx + 16'd1 == r_len);
                r_idx       <= r_idx + 16'd1;
                if (r_idx + 16'd1 == r_len) r_busy <= 1'b0;
            end
            if (i_cmd_valid && o_cmd_ready) begin
                if (i_cmd.kind == frr_pkg::CMD_DRAIN && i_cmd.count != 16'd0) begin
                    r_busy <= 1'b1;
                    r_idx  <= 16'd0;
                    r_len  <= w_len;
                end else begin
                    r_ov         <= 1'b1;
                    o_has_data   <= 1'b0;
                    o_data_byte  <= 8'd0;
                    o_has_reply  <= (i_cmd.kind != frr_pkg::CMD_STATUS);
                    o_reply_byte <= (i_cmd.kind == frr_pkg::CMD_STATUS) ? 8'd0 :
                                    (i_cmd.kind == frr_pkg::CMD_DRAIN) ? frr_pkg::C_ACK :
                                    i_cmd.code;
                    o_status     <= i_cmd.status;
                    o_last       <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_ov;

    a_idle_when_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && o_cmd_ready |-> !r_busy && !r_pend)
        else $error("command taken while draining");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < r_len) else $error("drain index past length");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_last && o_has_data |-> !r_busy)
        else $error("last flagged mid drain");

endmodule
